>>> rtl/ubd_pkg.sv
package ubd_pkg;

  localparam int unsigned BaudW  = 24;
  localparam int unsigned ClockW = 29;

  // Shift amounts for 16x and 8x oversampling
  localparam int unsigned OverShiftHigh = 4;
  localparam int unsigned OverShiftLow  = 3;

  // Widest divider: baud rate times 16
  localparam int unsigned DenW = BaudW + OverShiftHigh;

  localparam int unsigned FRACTION_BITS = 3;
  localparam int unsigned DIVISOR_BITS  = 16;

  typedef struct packed {
    logic x8;
    logic zero;
  } ubd_flags_t;

endpackage

>>> rtl/ubd_req_if.sv
interface ubd_req_if;
  import ubd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BaudW-1:0]  baud_rate;
  logic [ClockW-1:0] clock_hz;

  modport source (output valid, output baud_rate, output clock_hz, input ready);
  modport sink   (input valid, input baud_rate, input clock_hz, output ready);

endinterface

>>> rtl/ubd_rsp_if.sv
interface ubd_rsp_if #(
  parameter int unsigned DivisorBits  = ubd_pkg::DIVISOR_BITS,
  parameter int unsigned FractionBits = ubd_pkg::FRACTION_BITS
);
  localparam int unsigned FracW = (FractionBits > 0) ? FractionBits : 1;

  logic                   valid;
  logic                   ready;
  logic [DivisorBits-1:0] divisor_integer;
  logic [FracW-1:0]       divisor_fraction;
  logic                   oversample_x8;
  logic                   status;

  modport source (output valid, output divisor_integer, output divisor_fraction,
                  output oversample_x8, output status, input ready);
  modport sink   (input valid, input divisor_integer, input divisor_fraction,
                  input oversample_x8, input status, output ready);

endinterface

>>> rtl/uart_baud_divider_calc.sv
// UART fractional baud divisor calculator. Each request transaction carries a
// baud rate and a clock frequency; the response carries the integer divisor,
// the fraction in 1/2^FractionBits steps, the oversampling choice (16x unless
// the clock is below 16 times the baud rate) and a status that is set for a
// zero baud rate or an integer divisor outside 1 .. 2^DivisorBits-1. One
// transaction is accepted per clock while the response is not stalled, and
// responses come out in order. The path runs through one setup stage, a row
// of restoring-division cells that each produce one quotient bit, and the
// output register. A stalled response backs the row up; nothing is lost.
module uart_baud_divider_calc #(
  parameter int unsigned FractionBits = ubd_pkg::FRACTION_BITS,
  parameter int unsigned DivisorBits  = ubd_pkg::DIVISOR_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ubd_req_if.sink   req_i,
  ubd_rsp_if.source rsp_o
);
  import ubd_pkg::*;

  localparam int unsigned NumW  = ClockW + FractionBits + 1;
  localparam int unsigned FracW = (FractionBits > 0) ? FractionBits : 1;

  logic            vld   [NumW+1];
  logic            rdy   [NumW+1];
  logic [DenW-1:0] rem   [NumW+1];
  logic [DenW-1:0] den   [NumW+1];
  logic [NumW-1:0] work  [NumW+1];
  ubd_flags_t      flags [NumW+1];

  ubd_prep #(
    .FractionBits (FractionBits),
    .NumW         (NumW)
  ) u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (req_i.valid),
    .ready_o     (req_i.ready),
    .baud_rate_i (req_i.baud_rate),
    .clock_hz_i  (req_i.clock_hz),
    .valid_o     (vld[0]),
    .ready_i     (rdy[0]),
    .den_o       (den[0]),
    .num_o       (work[0]),
    .flags_o     (flags[0])
  );

  assign rem[0] = '0;

  for (genvar k = 0; k < NumW; k++) begin : g_cell
    ubd_div_cell #(
      .NumW (NumW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[k]),
      .ready_o (rdy[k]),
      .rem_i   (rem[k]),
      .den_i   (den[k]),
      .work_i  (work[k]),
      .flags_i (flags[k]),
      .valid_o (vld[k+1]),
      .ready_i (rdy[k+1]),
      .rem_o   (rem[k+1]),
      .den_o   (den[k+1]),
      .work_o  (work[k+1]),
      .flags_o (flags[k+1])
    );
  end

  ubd_post #(
    .FractionBits (FractionBits),
    .DivisorBits  (DivisorBits),
    .NumW         (NumW),
    .FracW        (FracW)
  ) u_post (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (vld[NumW]),
    .ready_o            (rdy[NumW]),
    .quot_i             (work[NumW]),
    .flags_i            (flags[NumW]),
    .valid_o            (rsp_o.valid),
    .ready_i            (rsp_o.ready),
    .divisor_integer_o  (rsp_o.divisor_integer),
    .divisor_fraction_o (rsp_o.divisor_fraction),
    .oversample_x8_o    (rsp_o.oversample_x8),
    .status_o           (rsp_o.status)
  );

  // A good response never carries a zero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.status |-> rsp_o.divisor_integer != '0)
    else $error("good response with zero divisor");

  // A failed response clears both divisor fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.status |->
      rsp_o.divisor_integer == '0 && rsp_o.divisor_fraction == '0)
    else $error("failed response with nonzero divisor");

  // Back pressure on the request side only arises from a full, stalled row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid && !rsp_o.ready)
    else $error("request stalled without output stall");

endmodule

>>> rtl/ubd_prep.sv
module ubd_prep #(
  parameter int unsigned FractionBits = ubd_pkg::FRACTION_BITS,
  parameter int unsigned NumW         = ubd_pkg::ClockW + ubd_pkg::FRACTION_BITS + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [ubd_pkg::BaudW-1:0]   baud_rate_i,
  input  logic [ubd_pkg::ClockW-1:0]  clock_hz_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [ubd_pkg::DenW-1:0]    den_o,
  output logic [NumW-1:0]             num_o,
  output ubd_pkg::ubd_flags_t         flags_o
);
  import ubd_pkg::*;

  logic              valid_q;
  logic [DenW-1:0]   den_d, den_q;
  logic [NumW-1:0]   num_d, num_q;
  ubd_flags_t        flags_d, flags_q;
  logic [ClockW-1:0] baud_x16;
  logic              over_high;

  assign baud_x16  = ClockW'({baud_rate_i, OverShiftHigh'(0)});
  assign over_high = (clock_hz_i >= baud_x16);

  always_comb begin
    den_d = over_high ? DenW'({baud_rate_i, OverShiftHigh'(0)})
                      : DenW'({baud_rate_i, OverShiftLow'(0)});
    // Round to nearest: add half the divider
    num_d = (NumW'(clock_hz_i) << FractionBits) + NumW'(den_d >> 1);
    flags_d.x8   = ~over_high;
    flags_d.zero = (baud_rate_i == '0);
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      den_q   <= den_d;
      num_q   <= num_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign den_o   = den_q;
  assign num_o   = num_q;
  assign flags_o = flags_q;

endmodule

>>> rtl/ubd_div_cell.sv
module ubd_div_cell #(
  parameter int unsigned NumW = ubd_pkg::ClockW + ubd_pkg::FRACTION_BITS + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic [ubd_pkg::DenW-1:0]  rem_i,
  input  logic [ubd_pkg::DenW-1:0]  den_i,
  input  logic [NumW-1:0]           work_i,
  input  ubd_pkg::ubd_flags_t       flags_i,
  output logic                      valid_o,
  input  logic                      ready_i,
  output logic [ubd_pkg::DenW-1:0]  rem_o,
  output logic [ubd_pkg::DenW-1:0]  den_o,
  output logic [NumW-1:0]           work_o,
  output ubd_pkg::ubd_flags_t       flags_o
);
  import ubd_pkg::*;

  logic            valid_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;
  logic            take;
  logic [DenW-1:0] rem_d, rem_q;
  logic [DenW-1:0] den_q;
  logic [NumW-1:0] work_d, work_q;
  ubd_flags_t      flags_q;

  // Bring down the next dividend bit; quotient bits fill in from the bottom
  assign trial  = {rem_i, work_i[NumW-1]};
  assign diff   = trial - {1'b0, den_i};
  assign take   = (trial >= {1'b0, den_i});
  assign rem_d  = take ? diff[DenW-1:0] : trial[DenW-1:0];
  assign work_d = {work_i[NumW-2:0], take};

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q   <= rem_d;
      den_q   <= den_i;
      work_q  <= work_d;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign work_o  = work_q;
  assign flags_o = flags_q;

endmodule

>>> rtl/ubd_post.sv
module ubd_post #(
  parameter int unsigned FractionBits = ubd_pkg::FRACTION_BITS,
  parameter int unsigned DivisorBits  = ubd_pkg::DIVISOR_BITS,
  parameter int unsigned NumW         = ubd_pkg::ClockW + ubd_pkg::FRACTION_BITS + 1,
  parameter int unsigned FracW        = (FractionBits > 0) ? FractionBits : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [NumW-1:0]        quot_i,
  input  ubd_pkg::ubd_flags_t    flags_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic [DivisorBits-1:0] divisor_integer_o,
  output logic [FracW-1:0]       divisor_fraction_o,
  output logic                   oversample_x8_o,
  output logic                   status_o
);
  import ubd_pkg::*;

  localparam int unsigned TopW = DivisorBits + FractionBits;

  logic                   valid_q;
  logic [DivisorBits-1:0] int_part;
  logic [FracW-1:0]       frac_part;
  logic                   in_range;
  logic [DivisorBits-1:0] int_d, int_q;
  logic [FracW-1:0]       frac_d, frac_q;
  logic                   x8_q;
  logic                   status_d, status_q;

  assign int_part = quot_i[TopW-1:FractionBits];

  if (FractionBits > 0) begin : g_frac
    assign frac_part = quot_i[FracW-1:0];
  end else begin : g_no_frac
    assign frac_part = '0;
  end

  // Integer part must be nonzero and fit the field
  assign in_range = (quot_i[NumW-1:TopW] == '0) && (int_part != '0);

  always_comb begin
    status_d = flags_i.zero | ~in_range;
    int_d    = status_d ? '0 : int_part;
    frac_d   = status_d ? '0 : frac_part;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      int_q    <= int_d;
      frac_q   <= frac_d;
      x8_q     <= flags_i.x8;
      status_q <= status_d;
    end
  end

  assign valid_o            = valid_q;
  assign divisor_integer_o  = int_q;
  assign divisor_fraction_o = frac_q;
  assign oversample_x8_o    = x8_q;
  assign status_o           = status_q;

endmodule
